[hw/rtl/vdib_pkg.sv]
// Package for the vertex deduplication index builder.
// Holds the request and response payload types, the sequencer state type and the shared constants.
// No dependencies.
package vdib_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned VIDX_W      = 10;

  typedef struct packed {
    logic [WORD_W-1:0] pos_x_bits;
    logic [WORD_W-1:0] pos_y_bits;
    logic [WORD_W-1:0] pos_z_bits;
    logic [WORD_W-1:0] norm_x_bits;
    logic [WORD_W-1:0] norm_y_bits;
    logic [WORD_W-1:0] norm_z_bits;
    logic [WORD_W-1:0] tex_u_bits;
    logic [WORD_W-1:0] tex_v_bits;
  } vtx_req_t;

  localparam int unsigned VTX_W = $bits(vtx_req_t);

  typedef struct packed {
    logic [VIDX_W-1:0] vertex_index;
    logic              newly_stored;
    logic              table_full;
  } vtx_rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_HOLD
  } vdib_state_e;

endpackage : vdib_pkg

[hw/rtl/vdib_table.sv]
// Unique vertex table: one write port, one read port, registered read data.
// Depends on vdib_pkg for the vertex width.
module vdib_table #(
  parameter int unsigned Depth = vdib_pkg::TABLE_DEPTH,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [AddrW-1:0]           wr_addr_i,
  input  logic [vdib_pkg::VTX_W-1:0] wr_data_i,
  input  logic                       rd_en_i,
  input  logic [AddrW-1:0]           rd_addr_i,
  output logic [vdib_pkg::VTX_W-1:0] rd_data_o
);
  import vdib_pkg::*;

  logic [VTX_W-1:0] mem_q [Depth];
  logic [VTX_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule : vdib_table

[hw/rtl/vdib_ctrl.sv]
// Lookup sequencer: scans newest entry first, compares, appends on a miss unless full.
// Depends on vdib_pkg; drives the vdib_table ports.
module vdib_ctrl #(
  parameter int unsigned Depth  = vdib_pkg::TABLE_DEPTH,
  parameter int unsigned AddrW  = $clog2(Depth),
  parameter int unsigned CountW = $clog2(Depth + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  vdib_pkg::vtx_req_t         in_req_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output vdib_pkg::vtx_rsp_t         out_rsp_o,
  output logic                       mem_we_o,
  output logic [AddrW-1:0]           mem_waddr_o,
  output logic [vdib_pkg::VTX_W-1:0] mem_wdata_o,
  output logic                       mem_re_o,
  output logic [AddrW-1:0]           mem_raddr_o,
  input  logic [vdib_pkg::VTX_W-1:0] mem_rdata_i
);
  import vdib_pkg::*;

  vdib_state_e      state_q, state_d;
  vtx_req_t         vtx_q, vtx_d;
  logic [CountW-1:0] count_q, count_d;
  logic [AddrW-1:0] rd_addr_q, rd_addr_d;
  logic             rd_more_q, rd_more_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [AddrW-1:0] cmp_idx_q, cmp_idx_d;
  vtx_rsp_t         res_q, res_d;
  logic             out_valid_q, out_valid_d;
  vtx_rsp_t         out_rsp_q, out_rsp_d;

  logic [CountW-1:0] count_m1;
  logic [31:0]       hit_idx32;
  logic [31:0]       new_idx32;
  logic              hit;
  logic              table_has_room;

  assign count_m1       = count_q - CountW'(1);
  assign hit_idx32      = 32'(cmp_idx_q);
  assign new_idx32      = 32'(count_q);
  assign hit            = cmp_vld_q && (mem_rdata_i == vtx_q);
  assign table_has_room = (count_q < CountW'(Depth));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rd_more_q   <= 1'b0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_more_q   <= rd_more_d;
      cmp_vld_q   <= cmp_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vtx_q     <= vtx_d;
    rd_addr_q <= rd_addr_d;
    cmp_idx_q <= cmp_idx_d;
    res_q     <= res_d;
    out_rsp_q <= out_rsp_d;
  end

  always_comb begin
    state_d     = state_q;
    vtx_d       = vtx_q;
    count_d     = count_q;
    rd_addr_d   = rd_addr_q;
    rd_more_d   = rd_more_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_rsp_d   = out_rsp_q;
    in_ready_o  = 1'b0;
    mem_we_o    = 1'b0;
    mem_re_o    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          vtx_d     = in_req_i;
          rd_more_d = (count_q != '0);
          rd_addr_d = count_m1[AddrW-1:0];
          state_d   = S_SCAN;
        end
      end
      S_SCAN: begin
        // One read is issued per cycle; its data is compared in the following cycle.
        if (rd_more_q) begin
          mem_re_o  = 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_addr_q;
          if (rd_addr_q == '0) begin
            rd_more_d = 1'b0;
          end else begin
            rd_addr_d = rd_addr_q - AddrW'(1);
          end
        end
        if (hit) begin
          res_d.vertex_index = hit_idx32[VIDX_W-1:0];
          res_d.newly_stored = 1'b0;
          res_d.table_full   = 1'b0;
          rd_more_d          = 1'b0;
          cmp_vld_d          = 1'b0;
          state_d            = S_HOLD;
        end else if (!rd_more_q) begin
          // Every stored entry has been compared without a match.
          if (table_has_room) begin
            mem_we_o           = 1'b1;
            count_d            = count_q + CountW'(1);
            res_d.vertex_index = new_idx32[VIDX_W-1:0];
            res_d.newly_stored = 1'b1;
            res_d.table_full   = 1'b0;
          end else begin
            res_d.vertex_index = '0;
            res_d.newly_stored = 1'b0;
            res_d.table_full   = 1'b1;
          end
          cmp_vld_d = 1'b0;
          state_d   = S_HOLD;
        end
      end
      S_HOLD: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_rsp_d   = res_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign mem_waddr_o = count_q[AddrW-1:0];
  assign mem_wdata_o = vtx_q;
  assign mem_raddr_o = rd_addr_q;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  a_read_below_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re_o |-> (CountW'(mem_raddr_o) < count_q))
    else $error("table read at or above the stored count");

  a_write_bumps_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |=> (count_q == $past(count_q) + CountW'(1)))
    else $error("append did not advance the stored count");

  a_count_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(Depth))
    else $error("stored count exceeds the table depth");

  a_flags_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_rsp_o.newly_stored && out_rsp_o.table_full))
    else $error("response flags both newly stored and full");

  a_full_only_at_depth : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && state_d == S_HOLD && res_d.table_full)
      |-> (count_q == CountW'(Depth)))
    else $error("full reported while the table has room");

endmodule : vdib_ctrl

[hw/rtl/vertex_dedup_index_builder.sv]
// Top level of the vertex deduplication index builder.
// Depends on vdib_pkg, vdib_ctrl and vdib_table.
//
//   channel   direction  handshake                payload
//   request   in         in_valid_i / in_ready_o  in_req_i   (vtx_req_t, eight 32-bit words)
//   response  out        out_valid_o / out_ready_i out_rsp_o (vtx_rsp_t)
//
// A request with N stored entries compares all N entries on a miss and stops at the match on a hit;
// the scan reads one table entry per cycle through the single read port of the table.
// The worst case is a miss that scans all TableDepth entries.
// Reset clears the stored count and the control state, not the table; the table contents are never read before written.
// A new request is taken while a finished response still waits in the output register;
// a stalled response holds the next result in the sequencer until the register frees.
module vertex_dedup_index_builder #(
  parameter int unsigned TableDepth = vdib_pkg::TABLE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  vdib_pkg::vtx_req_t in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output vdib_pkg::vtx_rsp_t out_rsp_o
);
  import vdib_pkg::*;

  localparam int unsigned AddrW  = $clog2(TableDepth);
  localparam int unsigned CountW = $clog2(TableDepth + 1);

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [VTX_W-1:0] mem_wdata;
  logic             mem_re;
  logic [AddrW-1:0] mem_raddr;
  logic [VTX_W-1:0] mem_rdata;

  vdib_ctrl #(
    .Depth  (TableDepth),
    .AddrW  (AddrW),
    .CountW (CountW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  vdib_table #(
    .Depth (TableDepth),
    .AddrW (AddrW)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i (mem_wdata),
    .rd_en_i   (mem_re),
    .rd_addr_i (mem_raddr),
    .rd_data_o (mem_rdata)
  );

endmodule : vertex_dedup_index_builder
